### sv/plc_pkg.sv
// Shared constants and item types for the particle line collision core.
`timescale 1ns / 1ps

package plc_pkg;

    // Field widths
    localparam int CoordWidth  = 24;
    localparam int RadiusWidth = 16;
    localparam int DampWidth   = 17;
    localparam int DampFrac    = 16;

    // Damping after reset, about 0.99 in Q1.16
    localparam logic [DampWidth-1:0] DampReset = 17'd64881;

    typedef struct packed {
        logic signed [CoordWidth-1:0] pos_x;
        logic signed [CoordWidth-1:0] pos_y;
        logic signed [CoordWidth-1:0] vel_x;
        logic signed [CoordWidth-1:0] vel_y;
        logic        [RadiusWidth-1:0] radius;
        logic signed [CoordWidth-1:0] line_x1;
        logic signed [CoordWidth-1:0] line_y1;
        logic signed [CoordWidth-1:0] line_x2;
        logic signed [CoordWidth-1:0] line_y2;
    } item_t;

    typedef struct packed {
        logic signed [CoordWidth-1:0] new_pos_x;
        logic signed [CoordWidth-1:0] new_pos_y;
        logic signed [CoordWidth-1:0] new_vel_x;
        logic signed [CoordWidth-1:0] new_vel_y;
        logic                         hit;
        logic                         degenerate_line;
    } result_t;

endpackage

### sv/plc_pipeline.sv
// Stalling arithmetic pipeline for the collision response, with output skid stage.
`timescale 1ns / 1ps

module plc_pipeline (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  plc_pkg::item_t                       item,
    input  logic [plc_pkg::DampWidth-1:0]        damping,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output plc_pkg::result_t                     result
);

    localparam int W     = plc_pkg::CoordWidth;
    localparam int RW    = plc_pkg::RadiusWidth;
    localparam int DW    = plc_pkg::DampWidth;
    localparam int D     = W + 1;          // endpoint differences
    localparam int AW    = 2 * D + 1;      // cross product magnitude
    localparam int LW    = 2 * D;          // squared length
    localparam int WM    = W + D;          // |v x d|
    localparam int NW    = WM + D;         // |v x d| * |d component|
    localparam int QW    = W;              // perpendicular quotient bits
    localparam int Chain = D + 2 + RW;     // sqrt, hit test, distance divide
    localparam int Stages = 3 + Chain;

    localparam logic [W+DW:0] RoundHalf = (W + DW + 1)'(1) << (plc_pkg::DampFrac - 1);
    localparam logic signed [W+2:0] CoordMax = {4'b0000, {(W-1){1'b1}}};
    localparam logic signed [W+2:0] CoordMin = {4'b1111, {(W-1){1'b0}}};

    typedef struct packed {
        logic signed [W-1:0]  px;
        logic signed [W-1:0]  py;
        logic signed [W-1:0]  vx;
        logic signed [W-1:0]  vy;
        logic        [RW-1:0] r;
        logic signed [D-1:0]  dx;
        logic signed [D-1:0]  dy;
        logic signed [D-1:0]  rx;
        logic signed [D-1:0]  ry;
        logic                 degen;
    } diff_t;

    typedef struct packed {
        logic signed [W-1:0]    px;
        logic signed [W-1:0]    py;
        logic signed [W-1:0]    vx;
        logic signed [W-1:0]    vy;
        logic        [RW-1:0]   r;
        logic signed [D-1:0]    dx;
        logic signed [D-1:0]    dy;
        logic                   degen;
        logic signed [2*D-1:0]  p_rydx;
        logic signed [2*D-1:0]  p_rxdy;
        logic signed [2*D-1:0]  sq_dx;
        logic signed [2*D-1:0]  sq_dy;
        logic signed [WM-1:0]   p_vxdy;
        logic signed [WM-1:0]   p_vydx;
        logic        [W+DW-1:0] dmx;
        logic        [W+DW-1:0] dmy;
    } prod_t;

    typedef struct packed {
        logic signed [W-1:0]    px;
        logic signed [W-1:0]    py;
        logic signed [W-1:0]    vx;
        logic signed [W-1:0]    vy;
        logic        [RW-1:0]   r;
        logic                   degen;
        logic signed [W:0]      dampx;
        logic signed [W:0]      dampy;
        logic                   sign_x;
        logic                   sign_y;
        logic        [AW-1:0]   arem;
        logic        [LW-1:0]   len_sq;
        logic        [LW-1:0]   sq_rem;
        logic        [D-1:0]    root;
        logic        [WM-1:0]   wmag;
        logic        [D-1:0]    adx;
        logic        [D-1:0]    ady;
        logic        [2*D-1:0]  plx;
        logic        [2*D-1:0]  ply;
        logic        [WM-1:0]   phx;
        logic        [WM-1:0]   phy;
        logic        [NW-1:0]   nx;
        logic        [NW-1:0]   ny;
        logic        [QW-1:0]   qx;
        logic        [QW-1:0]   qy;
        logic        [RW+D:0]   rlen;
        logic                   hit;
        logic        [RW-1:0]   gap;
    } carry_t;

    // One chain stage: the work done depends on the stage number only
    function automatic carry_t chain_step(input carry_t c, input int s);
        carry_t       n;
        logic [LW:0]  term;
        logic [NW:0]  dv;
        logic [AW:0]  dd;
        int           k;
        int           i;
        n = c;
        // Split products of |v x d| with each direction magnitude
        if (s == 0) begin
            n.plx = c.wmag[D-1:0] * c.ady;
            n.phx = c.wmag[WM-1:D] * c.ady;
            n.ply = c.wmag[D-1:0] * c.adx;
            n.phy = c.wmag[WM-1:D] * c.adx;
        end
        if (s == 1) begin
            n.nx = NW'(c.plx) + (NW'(c.phx) << D);
            n.ny = NW'(c.ply) + (NW'(c.phy) << D);
        end
        // Square root, one result bit per stage
        if (s <= D - 1) begin
            k = D - 1 - s;
            term = ((LW + 1)'(c.root) << (k + 1)) + ((LW + 1)'(1) << (2 * k));
            if ({1'b0, c.sq_rem} >= term) begin
                n.sq_rem = c.sq_rem - LW'(term);
                n.root   = c.root | (D'(1) << k);
            end
        end
        // Perpendicular component quotients, one bit per stage
        if (s >= 2 && s <= QW + 1) begin
            i  = QW + 1 - s;
            dv = (NW + 1)'(c.len_sq) << i;
            if ({1'b0, c.nx} >= dv) begin
                n.nx    = c.nx - NW'(dv);
                n.qx[i] = 1'b1;
            end
            if ({1'b0, c.ny} >= dv) begin
                n.ny    = c.ny - NW'(dv);
                n.qy[i] = 1'b1;
            end
        end
        // Hit test without the full quotient: gap <= r iff cross < (r + 1) * len
        if (s == D) begin
            n.rlen = ((RW + D + 1)'(c.r) + (RW + D + 1)'(1)) * c.root;
        end
        if (s == D + 1) begin
            n.hit = !c.degen && (c.arem < AW'(c.rlen));
        end
        // Distance quotient; below 2^RW whenever there is a hit
        if (s >= D + 2) begin
            i  = D + 1 + RW - s;
            dd = (AW + 1)'(c.root) << i;
            if ({1'b0, c.arem} >= dd) begin
                n.arem   = c.arem - AW'(dd);
                n.gap[i] = 1'b1;
            end
        end
        return n;
    endfunction

    function automatic logic signed [W-1:0] sat_coord(input logic signed [W+2:0] v);
        logic signed [W+2:0] t;
        t = v;
        if (v > CoordMax) begin
            t = CoordMax;
        end else if (v < CoordMin) begin
            t = CoordMin;
        end
        return t[W-1:0];
    endfunction

    diff_t            s1_reg, s1_next;
    prod_t            s2_reg, s2_next;
    carry_t           s3_reg, s3_next;
    carry_t           chain_reg  [Chain];
    carry_t           chain_next [Chain];
    logic [Stages-1:0] v_reg;
    logic              en;

    plc_pkg::result_t final_res;
    plc_pkg::result_t out_data_reg, out_data_next;
    plc_pkg::result_t skid_data_reg, skid_data_next;
    logic             out_valid_reg, out_valid_next;
    logic             skid_valid_reg, skid_valid_next;

    // Advance the pipeline stages while the skid stage is free
    assign en       = !skid_valid_reg;
    assign in_ready = en;

    // Endpoint differences and degenerate test
    always_comb
    begin
        s1_next.px    = item.pos_x;
        s1_next.py    = item.pos_y;
        s1_next.vx    = item.vel_x;
        s1_next.vy    = item.vel_y;
        s1_next.r     = item.radius;
        s1_next.dx    = D'(item.line_x2) - D'(item.line_x1);
        s1_next.dy    = D'(item.line_y2) - D'(item.line_y1);
        s1_next.rx    = D'(item.pos_x) - D'(item.line_x1);
        s1_next.ry    = D'(item.pos_y) - D'(item.line_y1);
        s1_next.degen = (item.line_x1 == item.line_x2) && (item.line_y1 == item.line_y2);
    end

    // Products
    always_comb
    begin
        logic [W-1:0] absvx;
        logic [W-1:0] absvy;
        absvx = s1_reg.vx[W-1] ? W'(-s1_reg.vx) : W'(s1_reg.vx);
        absvy = s1_reg.vy[W-1] ? W'(-s1_reg.vy) : W'(s1_reg.vy);
        s2_next.px     = s1_reg.px;
        s2_next.py     = s1_reg.py;
        s2_next.vx     = s1_reg.vx;
        s2_next.vy     = s1_reg.vy;
        s2_next.r      = s1_reg.r;
        s2_next.dx     = s1_reg.dx;
        s2_next.dy     = s1_reg.dy;
        s2_next.degen  = s1_reg.degen;
        s2_next.p_rydx = s1_reg.ry * s1_reg.dx;
        s2_next.p_rxdy = s1_reg.rx * s1_reg.dy;
        s2_next.sq_dx  = s1_reg.dx * s1_reg.dx;
        s2_next.sq_dy  = s1_reg.dy * s1_reg.dy;
        s2_next.p_vxdy = s1_reg.vx * s1_reg.dy;
        s2_next.p_vydx = s1_reg.vy * s1_reg.dx;
        s2_next.dmx    = absvx * damping;
        s2_next.dmy    = absvy * damping;
    end

    // Sums, magnitudes and rounded damping
    always_comb
    begin
        logic signed [AW-1:0] cdiff;
        logic signed [WM:0]   wdiff;
        logic        [W+DW:0] rx_sum;
        logic        [W+DW:0] ry_sum;
        logic signed [W:0]    mx;
        logic signed [W:0]    my;
        cdiff  = AW'(s2_reg.p_rydx) - AW'(s2_reg.p_rxdy);
        wdiff  = (WM + 1)'(s2_reg.p_vxdy) - (WM + 1)'(s2_reg.p_vydx);
        rx_sum = (W + DW + 1)'(s2_reg.dmx) + RoundHalf;
        ry_sum = (W + DW + 1)'(s2_reg.dmy) + RoundHalf;
        mx     = $signed({1'b0, rx_sum[plc_pkg::DampFrac+W-1:plc_pkg::DampFrac]});
        my     = $signed({1'b0, ry_sum[plc_pkg::DampFrac+W-1:plc_pkg::DampFrac]});
        s3_next        = '0;
        s3_next.px     = s2_reg.px;
        s3_next.py     = s2_reg.py;
        s3_next.vx     = s2_reg.vx;
        s3_next.vy     = s2_reg.vy;
        s3_next.r      = s2_reg.r;
        s3_next.degen  = s2_reg.degen;
        s3_next.dampx  = s2_reg.vx[W-1] ? -mx : mx;
        s3_next.dampy  = s2_reg.vy[W-1] ? -my : my;
        s3_next.arem   = cdiff[AW-1] ? $unsigned(-cdiff) : $unsigned(cdiff);
        s3_next.len_sq = LW'($unsigned(s2_reg.sq_dx)) + LW'($unsigned(s2_reg.sq_dy));
        s3_next.sq_rem = s3_next.len_sq;
        s3_next.wmag   = wdiff[WM] ? WM'($unsigned(-wdiff)) : WM'($unsigned(wdiff));
        s3_next.adx    = s2_reg.dx[D-1] ? $unsigned(-s2_reg.dx) : $unsigned(s2_reg.dx);
        s3_next.ady    = s2_reg.dy[D-1] ? $unsigned(-s2_reg.dy) : $unsigned(s2_reg.dy);
        // vp_x carries the sign of w * dy, vp_y that of -w * dx
        s3_next.sign_x = wdiff[WM] ^ s2_reg.dy[D-1];
        s3_next.sign_y = wdiff[WM] ^ ~s2_reg.dx[D-1];
    end

    // Iterative stages
    for (genvar g = 0; g < Chain; g++) begin : g_chain
        if (g == 0) begin : g_first
            assign chain_next[g] = chain_step(s3_reg, g);
        end else begin : g_rest
            assign chain_next[g] = chain_step(chain_reg[g-1], g);
        end
    end

    // Response and saturation
    always_comb
    begin
        carry_t                c;
        logic signed [W:0]     vpx;
        logic signed [W:0]     vpy;
        logic signed [W+2:0]   push;
        logic signed [W+2:0]   nvx;
        logic signed [W+2:0]   nvy;
        logic signed [W+2:0]   npx;
        logic signed [W+2:0]   npy;
        c    = chain_reg[Chain-1];
        vpx  = c.sign_x ? -$signed({1'b0, c.qx}) : $signed({1'b0, c.qx});
        vpy  = c.sign_y ? -$signed({1'b0, c.qy}) : $signed({1'b0, c.qy});
        push = $signed((W + 3)'(c.r)) - $signed((W + 3)'(c.gap));
        nvx  = (W + 3)'(c.dampx) - ((W + 3)'(vpx) <<< 1);
        nvy  = (W + 3)'(c.dampy) - ((W + 3)'(vpy) <<< 1);
        npx  = (W + 3)'(c.px);
        npy  = (W + 3)'(c.py);
        // Push against the sign of the perpendicular component; none when it is zero
        if (c.qx != '0) begin
            npx = c.sign_x ? npx + push : npx - push;
        end
        if (c.qy != '0) begin
            npy = c.sign_y ? npy + push : npy - push;
        end
        final_res.hit             = c.hit;
        final_res.degenerate_line = c.degen;
        if (c.hit) begin
            final_res.new_pos_x = sat_coord(npx);
            final_res.new_pos_y = sat_coord(npy);
            final_res.new_vel_x = sat_coord(nvx);
            final_res.new_vel_y = sat_coord(nvy);
        end else begin
            final_res.new_pos_x = c.px;
            final_res.new_pos_y = c.py;
            final_res.new_vel_x = c.vx;
            final_res.new_vel_y = c.vy;
        end
    end

    // Output register with one skid entry
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || out_ready) begin
            if (skid_valid_reg) begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next = v_reg[Stages-1];
                out_data_next  = final_res;
            end
        end else if (v_reg[Stages-1] && en) begin
            skid_valid_next = 1'b1;
            skid_data_next  = final_res;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            v_reg          <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (en) begin
                v_reg <= {v_reg[Stages-2:0], in_valid};
            end
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (en) begin
            s1_reg    <= s1_next;
            s2_reg    <= s2_next;
            s3_reg    <= s3_next;
            chain_reg <= chain_next;
        end
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign out_valid = out_valid_reg;
    assign result    = out_data_reg;

`ifndef NO_ASSERTIONS
    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held without an output item");

    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !out_ready && v_reg[Stages-1]))
        else $error("skid entry filled without a stalled result");

    a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg && out_ready |=> !skid_valid_reg)
        else $error("skid entry not drained on a taken output");

    a_hit_not_degen: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg.hit |-> !out_data_reg.degenerate_line)
        else $error("hit reported on a degenerate line");
`endif

endmodule

### sv/particle_line_collision_core.sv
// Top level of the particle line collision core: ports, damping register, pipeline.
`timescale 1ns / 1ps

//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+--------------------------------------
//  in       | input     | in_valid / in_ready  | pos, vel, radius, line endpoints
//  out      | output    | out_valid / out_ready| new pos, new vel, hit, degenerate_line
//  cfg      | input     | cfg_valid / cfg_ready| damping_factor
//
//  One item per cycle while the skid stage is free; accepted items pass through
//  three front stages, the 25-step square root of the squared length, two
//  hit-test steps and the 16-step distance divide, then the output register.
//  Reset clears the valid bits and loads damping 0.99; no clearing pass.
//  A stalled output parks one result in a skid stage, then the whole pipe holds.

module particle_line_collision_core (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [plc_pkg::CoordWidth-1:0]  pos_x,
    input  logic signed [plc_pkg::CoordWidth-1:0]  pos_y,
    input  logic signed [plc_pkg::CoordWidth-1:0]  vel_x,
    input  logic signed [plc_pkg::CoordWidth-1:0]  vel_y,
    input  logic        [plc_pkg::RadiusWidth-1:0] radius,
    input  logic signed [plc_pkg::CoordWidth-1:0]  line_x1,
    input  logic signed [plc_pkg::CoordWidth-1:0]  line_y1,
    input  logic signed [plc_pkg::CoordWidth-1:0]  line_x2,
    input  logic signed [plc_pkg::CoordWidth-1:0]  line_y2,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [plc_pkg::CoordWidth-1:0]  new_pos_x,
    output logic signed [plc_pkg::CoordWidth-1:0]  new_pos_y,
    output logic signed [plc_pkg::CoordWidth-1:0]  new_vel_x,
    output logic signed [plc_pkg::CoordWidth-1:0]  new_vel_y,
    output logic                                  hit,
    output logic                                  degenerate_line,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic        [plc_pkg::DampWidth-1:0]   damping_factor
);

    logic [plc_pkg::DampWidth-1:0] damping_reg;
    plc_pkg::item_t                item;
    plc_pkg::result_t              result;

    // Damping register, always writable
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            damping_reg <= plc_pkg::DampReset;
        end else if (cfg_valid) begin
            damping_reg <= damping_factor;
        end
    end

    // Gather the input item
    always_comb
    begin
        item.pos_x   = pos_x;
        item.pos_y   = pos_y;
        item.vel_x   = vel_x;
        item.vel_y   = vel_y;
        item.radius  = radius;
        item.line_x1 = line_x1;
        item.line_y1 = line_y1;
        item.line_x2 = line_x2;
        item.line_y2 = line_y2;
    end

    plc_pipeline u_pipeline (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .item      (item),
        .damping   (damping_reg),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .result    (result)
    );

    assign new_pos_x       = result.new_pos_x;
    assign new_pos_y       = result.new_pos_y;
    assign new_vel_x       = result.new_vel_x;
    assign new_vel_y       = result.new_vel_y;
    assign hit             = result.hit;
    assign degenerate_line = result.degenerate_line;

endmodule
